@@ rtl/icm_pkg.sv @@
// shared types, palette tables and helpers for the interpolated palette colormap
`timescale 1ns / 1ps

package icm_pkg;

    // palette selection codes
    typedef enum logic [2:0] {
        MODE_RAINBOW          = 3'd0,
        MODE_GREEN_RED        = 3'd1,
        MODE_GREEN_WHITE      = 3'd2,
        MODE_GREEN            = 3'd3,
        MODE_WHITE_BLACK_GRAY = 3'd4,
        MODE_GRAYSCALE        = 3'd5,
        MODE_BLACK_GRAYSCALE  = 3'd6
    } t_mode;

    // palette entry value, units of 1/1020
    typedef logic signed [11:0] t_pal_val;

    // per-item flags for the background color
    typedef struct packed {
        logic neg;
        logic clear;
    } t_tag;

    // stage advance enables handed to a two-stage section
    typedef struct packed {
        logic first;
        logic second;
    } t_adv;

    localparam int PalTables  = 7;
    localparam int PalEntries = 12;
    localparam int Channels   = 3;
    localparam int Taps       = 4;

    localparam logic [7:0] BYTE_MAX = 8'hFF;
    localparam logic [7:0] BYTE_MIN = 8'h00;

    localparam logic [3:0] PAL_COUNT [PalTables] = '{
        4'd11, 4'd11, 4'd7, 4'd6, 4'd6, 4'd0, 4'd0
    };

    localparam t_pal_val PAL_TABLE [PalTables][PalEntries][Channels] = '{
        '{ // rainbow
            '{12'sd1020, 12'sd0, 12'sd0},    '{12'sd592, 12'sd0, 12'sd844},
            '{12'sd592, 12'sd0, 12'sd844},   '{12'sd300, 12'sd0, 12'sd520},
            '{12'sd0, 12'sd0, 12'sd1020},    '{12'sd0, 12'sd510, 12'sd0},
            '{12'sd1020, 12'sd1020, 12'sd0}, '{12'sd1020, 12'sd510, 12'sd0},
            '{12'sd1020, 12'sd0, 12'sd0},    '{12'sd1020, 12'sd0, 12'sd0},
            '{-12'sd510, 12'sd0, 12'sd0},    '{12'sd765, 12'sd0, 12'sd0}
        },
        '{ // green-red
            '{12'sd0, 12'sd1020, 12'sd0},    '{12'sd0, 12'sd1020, 12'sd0},
            '{12'sd0, 12'sd1020, 12'sd0},    '{12'sd0, 12'sd1020, 12'sd0},
            '{12'sd0, 12'sd1020, 12'sd0},    '{12'sd1020, 12'sd1020, 12'sd0},
            '{12'sd1020, 12'sd1020, 12'sd0}, '{12'sd1020, 12'sd0, 12'sd0},
            '{12'sd1020, 12'sd0, 12'sd0},    '{12'sd1020, 12'sd0, 12'sd0},
            '{-12'sd510, 12'sd0, 12'sd0},    '{12'sd765, 12'sd0, 12'sd0}
        },
        '{ // green-white
            '{12'sd0, 12'sd1020, 12'sd0},       '{12'sd0, 12'sd1020, 12'sd0},
            '{12'sd0, 12'sd1020, 12'sd0},       '{12'sd1020, 12'sd1020, 12'sd1020},
            '{12'sd1020, 12'sd1020, 12'sd1020}, '{12'sd1020, 12'sd1020, 12'sd1020},
            '{12'sd1020, 12'sd1020, 12'sd1020}, '{12'sd1020, 12'sd1020, 12'sd1020},
            '{12'sd0, 12'sd0, 12'sd0},          '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0},          '{12'sd0, 12'sd0, 12'sd0}
        },
        '{ // green
            '{12'sd0, 12'sd0, 12'sd0},    '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd1020, 12'sd0}, '{12'sd0, 12'sd1020, 12'sd0},
            '{12'sd0, 12'sd1020, 12'sd0}, '{12'sd0, 12'sd1020, 12'sd0},
            '{12'sd0, 12'sd1020, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0},    '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0},    '{12'sd0, 12'sd0, 12'sd0}
        },
        '{ // white-black-gray
            '{12'sd1020, 12'sd1020, 12'sd1020}, '{12'sd1020, 12'sd1020, 12'sd1020},
            '{12'sd0, 12'sd0, 12'sd0},          '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0},          '{12'sd510, 12'sd510, 12'sd510},
            '{12'sd510, 12'sd510, 12'sd510},    '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0},          '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0},          '{12'sd0, 12'sd0, 12'sd0}
        },
        '{ // grayscale
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0}
        },
        '{ // black-grayscale
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0},
            '{12'sd0, 12'sd0, 12'sd0}, '{12'sd0, 12'sd0, 12'sd0}
        }
    };

    // unused mode code falls back to rainbow
    function automatic t_mode palette_select(input logic [2:0] mode);
        t_mode sel;
        case (mode)
            MODE_RAINBOW:          sel = MODE_RAINBOW;
            MODE_GREEN_RED:        sel = MODE_GREEN_RED;
            MODE_GREEN_WHITE:      sel = MODE_GREEN_WHITE;
            MODE_GREEN:            sel = MODE_GREEN;
            MODE_WHITE_BLACK_GRAY: sel = MODE_WHITE_BLACK_GRAY;
            MODE_GRAYSCALE:        sel = MODE_GRAYSCALE;
            MODE_BLACK_GRAYSCALE:  sel = MODE_BLACK_GRAYSCALE;
            default:               sel = MODE_RAINBOW;
        endcase
        return sel;
    endfunction

    // palettes whose background is transparent black
    function automatic logic palette_clear_bg(input t_mode sel);
        return (sel == MODE_GREEN_WHITE) || (sel == MODE_GREEN) ||
               (sel == MODE_BLACK_GRAYSCALE);
    endfunction

endpackage

@@ rtl/icm_index.sv @@
// scale and index stages: position times entry count, clamped taps, palette lookup
`timescale 1ns / 1ps

module icm_index #(
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  icm_pkg::t_adv        i_adv,
    input  logic signed [17:0]   i_position,
    input  logic [2:0]           i_mode,
    output icm_pkg::t_pal_val    o_tap [icm_pkg::Taps][icm_pkg::Channels],
    output logic [POSITION_FRACTION_BITS-1:0] o_frac,
    output icm_pkg::t_tag        o_tag
);

    localparam int FracW = POSITION_FRACTION_BITS;
    localparam int ScW   = 21;              // n * position, n <= 11
    localparam int ExtW  = ScW + FracW;

    // stage 1
    icm_pkg::t_mode   n_s1_sel, r_s1_sel;
    logic [ScW-1:0]   n_s1_f, r_s1_f;
    icm_pkg::t_tag    n_s1_tag, r_s1_tag;

    always_comb begin
        n_s1_sel       = icm_pkg::palette_select(i_mode);
        n_s1_f         = ScW'(icm_pkg::PAL_COUNT[n_s1_sel]) * ScW'(i_position[16:0]);
        n_s1_tag.neg   = i_position[17];
        n_s1_tag.clear = icm_pkg::palette_clear_bg(n_s1_sel);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.first) begin
            r_s1_sel <= n_s1_sel;
            r_s1_f   <= n_s1_f;
            r_s1_tag <= n_s1_tag;
        end
    end

    // stage 2
    logic [ExtW-1:0]  f_ext;
    logic [ScW:0]     fl, fl_m1, fl_p1, fl_p2, cnt;
    logic [3:0]       idx [icm_pkg::Taps];
    logic             over;
    logic [FracW-1:0] n_s2_frac, r_s2_frac;
    icm_pkg::t_pal_val n_s2_tap [icm_pkg::Taps][icm_pkg::Channels];
    icm_pkg::t_pal_val r_s2_tap [icm_pkg::Taps][icm_pkg::Channels];
    icm_pkg::t_tag    r_s2_tag;

    always_comb begin
        f_ext = ExtW'(r_s1_f);
        fl    = (ScW+1)'(f_ext[ExtW-1:FracW]);
        cnt   = (ScW+1)'(icm_pkg::PAL_COUNT[r_s1_sel]);
        fl_m1 = fl - (ScW+1)'(1);
        fl_p1 = fl + (ScW+1)'(1);
        fl_p2 = fl + (ScW+1)'(2);
        over  = fl > cnt;
        idx[0] = (fl == '0) ? 4'd0 : ((fl_m1 > cnt) ? cnt[3:0] : fl_m1[3:0]);
        idx[1] = over ? cnt[3:0] : fl[3:0];
        idx[2] = (fl_p1 > cnt) ? cnt[3:0] : fl_p1[3:0];
        idx[3] = (fl_p2 > cnt) ? cnt[3:0] : fl_p2[3:0];
        // past the top all taps hit the last entry, so the weight drops out
        n_s2_frac = over ? '0 : f_ext[FracW-1:0];
        for (int k = 0; k < icm_pkg::Taps; k++) begin
            for (int c = 0; c < icm_pkg::Channels; c++) begin
                n_s2_tap[k][c] = icm_pkg::PAL_TABLE[r_s1_sel][idx[k]][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.second) begin
            r_s2_frac <= n_s2_frac;
            r_s2_tap  <= n_s2_tap;
            r_s2_tag  <= r_s1_tag;
        end
    end

    assign o_tap  = r_s2_tap;
    assign o_frac = r_s2_frac;
    assign o_tag  = r_s2_tag;

endmodule

@@ rtl/icm_blend.sv @@
// blend stages: weighted tap products, channel sums and byte saturation
`timescale 1ns / 1ps

module icm_blend #(
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  icm_pkg::t_adv        i_adv,
    input  icm_pkg::t_pal_val    i_tap [icm_pkg::Taps][icm_pkg::Channels],
    input  logic [POSITION_FRACTION_BITS-1:0] i_frac,
    input  icm_pkg::t_tag        i_tag,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_alpha
);

    localparam int FracW = POSITION_FRACTION_BITS;
    localparam int WgtW  = FracW + 2;
    localparam int ProdW = FracW + 15;
    localparam int ShW   = ProdW - FracW - 4;
    localparam logic [WgtW-1:0] Half = WgtW'(1) << FracW;

    // stage 3: tap weights in order 1-s, 1-t, s, t
    logic [WgtW-1:0]         wgt [icm_pkg::Taps];
    logic signed [ProdW-1:0] n_s3_prod [icm_pkg::Taps][icm_pkg::Channels];
    logic signed [ProdW-1:0] r_s3_prod [icm_pkg::Taps][icm_pkg::Channels];
    icm_pkg::t_tag           r_s3_tag;

    always_comb begin
        wgt[0] = Half - WgtW'(i_frac);
        wgt[1] = (Half << 1) - WgtW'(i_frac);
        wgt[2] = Half + WgtW'(i_frac);
        wgt[3] = WgtW'(i_frac);
        for (int k = 0; k < icm_pkg::Taps; k++) begin
            for (int c = 0; c < icm_pkg::Channels; c++) begin
                n_s3_prod[k][c] = ProdW'(i_tap[k][c]) * ProdW'($signed({1'b0, wgt[k]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.first) begin
            r_s3_prod <= n_s3_prod;
            r_s3_tag  <= i_tag;
        end
    end

    // stage 4
    logic signed [ProdW-1:0] acc [icm_pkg::Channels];
    logic [ShW-1:0]          sh  [icm_pkg::Channels];
    logic [7:0]              chan [icm_pkg::Channels];
    logic [7:0]              bg;
    logic [7:0]              n_red, n_green, n_blue, n_alpha;
    logic [7:0]              r_red, r_green, r_blue, r_alpha;

    always_comb begin
        for (int c = 0; c < icm_pkg::Channels; c++) begin
            acc[c] = r_s3_prod[0][c] + r_s3_prod[1][c] + r_s3_prod[2][c]
                   + r_s3_prod[3][c];
            sh[c]  = acc[c][ProdW-1:FracW+4];
            if (acc[c][ProdW-1]) begin
                chan[c] = icm_pkg::BYTE_MIN;
            end else if (sh[c] > ShW'(icm_pkg::BYTE_MAX)) begin
                chan[c] = icm_pkg::BYTE_MAX;
            end else begin
                chan[c] = sh[c][7:0];
            end
        end
        bg = r_s3_tag.clear ? icm_pkg::BYTE_MIN : icm_pkg::BYTE_MAX;
        if (r_s3_tag.neg) begin
            n_red   = bg;
            n_green = bg;
            n_blue  = bg;
            n_alpha = bg;
        end else begin
            n_red   = chan[0];
            n_green = chan[1];
            n_blue  = chan[2];
            n_alpha = icm_pkg::BYTE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.second) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

endmodule

@@ rtl/interpolated_palette_colormap_top.sv @@
// top level of the interpolated palette colormap pipeline
`timescale 1ns / 1ps

// interpolated palette colormap
// input channel: i_valid / o_stall carry one signed position beat (i_position);
//   a beat is taken on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry one rgba beat (o_red .. o_alpha);
//   a beat leaves on a rising edge with o_valid high and i_stall low
// configuration: i_palette_mode_we writes i_palette_mode on the rising edge;
//   change it only while no beat is in flight
// pipeline: four register stages (scale, tap lookup, weighted products,
//   sum and saturate) that a beat passes in that order before it reaches
//   the output; one beat per cycle sustained with the receiver never
//   stalling
// the per-stage valid bits let bubbles collapse, so a stalled output still
//   takes new beats until every stage is full; o_stall follows i_stall
//   through that chain combinationally and nothing is dropped or repeated
// reset (synchronous, active low) empties the pipeline and selects rainbow

module interpolated_palette_colormap_top #(
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [17:0] i_position,
    input  logic               i_palette_mode_we,
    input  logic [2:0]         i_palette_mode,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha
);

    logic [2:0] r_mode;
    logic       r_v1, r_v2, r_v3, r_v4;
    logic       n_v1, n_v2, n_v3, n_v4;
    logic       en1, en2, en3, en4;

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        en4  = !r_v4 || !i_stall;
        en3  = !r_v3 || en4;
        en2  = !r_v2 || en3;
        en1  = !r_v1 || en2;
        n_v1 = en1 ? i_valid : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        n_v3 = en3 ? r_v2 : r_v3;
        n_v4 = en4 ? r_v3 : r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_mode <= icm_pkg::MODE_RAINBOW;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
            if (i_palette_mode_we) begin
                r_mode <= i_palette_mode;
            end
        end
    end

    icm_pkg::t_adv     adv_front, adv_back;
    icm_pkg::t_pal_val tap [icm_pkg::Taps][icm_pkg::Channels];
    logic [POSITION_FRACTION_BITS-1:0] frac;
    icm_pkg::t_tag     tag;

    assign adv_front.first  = en1;
    assign adv_front.second = en2;
    assign adv_back.first   = en3;
    assign adv_back.second  = en4;

    // scale by entry count, clamp taps, look up palette
    icm_index #(
        .POSITION_FRACTION_BITS(POSITION_FRACTION_BITS)
    ) u_index (
        .i_clk      (i_clk),
        .i_adv      (adv_front),
        .i_position (i_position),
        .i_mode     (r_mode),
        .o_tap      (tap),
        .o_frac     (frac),
        .o_tag      (tag)
    );

    // weight, sum, shift down to bytes; background handled here
    icm_blend #(
        .POSITION_FRACTION_BITS(POSITION_FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_adv   (adv_back),
        .i_tap   (tap),
        .i_frac  (frac),
        .i_tag   (tag),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_alpha (o_alpha)
    );

    assign o_stall = !en1;
    assign o_valid = r_v4;

endmodule

@@ tb/sv/interpolated_palette_colormap_top_tb.sv @@
// self-checking testbench for the interpolated palette colormap top level
`timescale 1ns / 1ps

module interpolated_palette_colormap_top_tb;

    localparam int FRAC = 16;
    // mode code with no palette of its own, falls back to rainbow
    localparam logic [2:0] MODE_SPARE = 3'd7;
    localparam int NUM_PHASES = 14;
    localparam int BEATS_PER_PHASE = 85;
    // reset default first, then every mode, the unused code and six modes again
    localparam logic [2:0] PHASE_MODE [NUM_PHASES] = '{
        icm_pkg::MODE_RAINBOW, icm_pkg::MODE_GREEN_RED, icm_pkg::MODE_GREEN_WHITE,
        icm_pkg::MODE_GREEN, icm_pkg::MODE_WHITE_BLACK_GRAY, icm_pkg::MODE_GRAYSCALE,
        icm_pkg::MODE_BLACK_GRAYSCALE, MODE_SPARE,
        icm_pkg::MODE_RAINBOW, icm_pkg::MODE_BLACK_GRAYSCALE, icm_pkg::MODE_GREEN_WHITE,
        icm_pkg::MODE_WHITE_BLACK_GRAY, icm_pkg::MODE_GREEN_RED, icm_pkg::MODE_GREEN
    };
    // field extremes, background, palette ends, first segment and overrange
    localparam int DIRECTED [13] = '{
        -131072, -65536, -1, 0, 1, 5958, 32768, 59578, 65535, 65536, 65537,
        98304, 131071
    };

    // three palette channels, index 0 is red
    typedef logic [2:0][11:0] t_shade;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [17:0] pos;
    } t_rgba;

    // expected colors in order, with a private copy of the mode register
    class color_board;
        t_rgba      color_q[$];
        logic [2:0] mode_reg;
        int         errors;

        function new();
            mode_reg = icm_pkg::MODE_RAINBOW;
            errors = 0;
        endfunction

        function icm_pkg::t_mode current_sel();
            if (mode_reg == MODE_SPARE) return icm_pkg::MODE_RAINBOW;
            return icm_pkg::t_mode'(mode_reg);
        endfunction

        function int entry_count(icm_pkg::t_mode sel);
            case (sel)
                icm_pkg::MODE_RAINBOW, icm_pkg::MODE_GREEN_RED:      return 11;
                icm_pkg::MODE_GREEN_WHITE:                           return 7;
                icm_pkg::MODE_GREEN, icm_pkg::MODE_WHITE_BLACK_GRAY: return 6;
                default:                                             return 0;
            endcase
        endfunction

        function t_shade rgb(int r, int g, int b);
            return {12'(b), 12'(g), 12'(r)};
        endfunction

        function t_shade palette_entry(icm_pkg::t_mode sel, longint idx);
            t_shade e;
            e = rgb(0, 0, 0);
            case (sel)
                icm_pkg::MODE_RAINBOW: begin
                    case (idx)
                        0, 8, 9: e = rgb(1020, 0, 0);
                        1, 2:    e = rgb(592, 0, 844);
                        3:       e = rgb(300, 0, 520);
                        4:       e = rgb(0, 0, 1020);
                        5:       e = rgb(0, 510, 0);
                        6:       e = rgb(1020, 1020, 0);
                        7:       e = rgb(1020, 510, 0);
                        10:      e = rgb(-510, 0, 0);
                        11:      e = rgb(765, 0, 0);
                        default: e = rgb(0, 0, 0);
                    endcase
                end
                icm_pkg::MODE_GREEN_RED: begin
                    case (idx)
                        0, 1, 2, 3, 4: e = rgb(0, 1020, 0);
                        5, 6:          e = rgb(1020, 1020, 0);
                        7, 8, 9:       e = rgb(1020, 0, 0);
                        10:            e = rgb(-510, 0, 0);
                        11:            e = rgb(765, 0, 0);
                        default:       e = rgb(0, 0, 0);
                    endcase
                end
                icm_pkg::MODE_GREEN_WHITE: begin
                    case (idx)
                        0, 1, 2:       e = rgb(0, 1020, 0);
                        3, 4, 5, 6, 7: e = rgb(1020, 1020, 1020);
                        default:       e = rgb(0, 0, 0);
                    endcase
                end
                icm_pkg::MODE_GREEN: begin
                    if (idx >= 2 && idx <= 6) e = rgb(0, 1020, 0);
                end
                icm_pkg::MODE_WHITE_BLACK_GRAY: begin
                    case (idx)
                        0, 1:    e = rgb(1020, 1020, 1020);
                        5, 6:    e = rgb(510, 510, 510);
                        default: e = rgb(0, 0, 0);
                    endcase
                end
                default: e = rgb(0, 0, 0);
            endcase
            return e;
        endfunction

        function logic [7:0] clip_byte(longint acc);
            if (acc < 0) return 8'h00;
            acc = acc >>> (FRAC + 4);
            if (acc > 255) return 8'hFF;
            return acc[7:0];
        endfunction

        // four clamped taps blended with weights t and 1/2 + t, exact integers
        function t_rgba predict_color(logic signed [17:0] pos);
            t_rgba          c;
            icm_pkg::t_mode sel;
            longint         n, f, fl, one, t, s, acc, hi;
            longint         tap [4];
            t_shade         e [4];
            logic [7:0]     v [3];
            logic [7:0]     bg;
            sel = current_sel();
            c.pos = pos;
            if (pos < 0) begin
                bg = (sel == icm_pkg::MODE_GREEN_WHITE || sel == icm_pkg::MODE_GREEN ||
                      sel == icm_pkg::MODE_BLACK_GRAYSCALE) ? 8'h00 : 8'hFF;
                c.red = bg;
                c.green = bg;
                c.blue = bg;
                c.alpha = bg;
                return c;
            end
            n = entry_count(sel);
            f = n * longint'(pos);
            fl = f >>> FRAC;
            for (int j = 0; j < 4; j++) begin
                hi = fl - 1 + j;
                if (hi < 0) hi = 0;
                if (hi > n) hi = n;
                tap[j] = hi;
                e[j] = palette_entry(sel, hi);
            end
            one = longint'(1) << (FRAC + 1);
            t = f - (tap[1] << FRAC);
            s = (one >>> 1) + t;
            for (int ch = 0; ch < 3; ch++) begin
                acc = longint'($signed(e[0][ch])) * (one - s)
                    + longint'($signed(e[2][ch])) * s
                    + longint'($signed(e[1][ch])) * (one - t)
                    + longint'($signed(e[3][ch])) * t;
                v[ch] = clip_byte(acc);
            end
            c.red = v[0];
            c.green = v[1];
            c.blue = v[2];
            c.alpha = 8'hFF;
            return c;
        endfunction

        function void note_position(logic signed [17:0] pos);
            color_q.push_back(predict_color(pos));
        endfunction

        task report_mismatch(string what, int got, int want, int pos);
            $display("color mismatch at %0t: %s got %0d want %0d (position %0d)",
                     $time, what, got, want, pos);
            errors++;
        endtask

        task check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
            t_rgba w;
            if (color_q.size() == 0) begin
                report_mismatch("unexpected beat, red", r, -1, 0);
                return;
            end
            w = color_q.pop_front();
            if (r !== w.red)   report_mismatch("red", r, w.red, w.pos);
            if (g !== w.green) report_mismatch("green", g, w.green, w.pos);
            if (b !== w.blue)  report_mismatch("blue", b, w.blue, w.pos);
            if (a !== w.alpha) report_mismatch("alpha", a, w.alpha, w.pos);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [17:0] i_position;
    logic               i_palette_mode_we;
    logic [2:0]         i_palette_mode;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [7:0]         o_alpha;

    // both sides run without idling while this is set
    logic calm;

    color_board board;

    interpolated_palette_colormap_top #(
        .POSITION_FRACTION_BITS(FRAC)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_position       (i_position),
        .i_palette_mode_we(i_palette_mode_we),
        .i_palette_mode   (i_palette_mode),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha)
    );

    always #1 i_clk = ~i_clk;

    // receiver back-pressure, changed only on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 23);
        end
    end

    // every beat that leaves the block is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_color(o_red, o_green, o_blue, o_alpha);
        end
    end

    // mostly in-range positions, some overrange, some background, and some
    // right around the palette segment boundaries of the current mode
    function automatic logic signed [17:0] random_position();
        int pick;
        int n;
        int p;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            p = $urandom_range(0, 65536);
        end else if (pick < 70) begin
            p = $urandom_range(65537, 131071);
        end else if (pick < 85) begin
            p = -int'($urandom_range(1, 131072));
        end else begin
            n = board.entry_count(board.current_sel());
            if (n == 0) n = 11;
            p = int'($urandom_range(0, n)) * 65536 / n + int'($urandom_range(0, 2)) - 1;
        end
        return 18'(p);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high so back-to-back beats need no extra assignment
    task automatic send_position(input logic signed [17:0] pos);
        while (!calm && $urandom_range(0, 99) < 23) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        board.note_position(pos);
        @(negedge i_clk);
    endtask

    // called at a falling edge with the pipeline empty
    task automatic write_mode(input logic [2:0] mode);
        i_palette_mode_we <= 1'b1;
        i_palette_mode <= mode;
        @(negedge i_clk);
        i_palette_mode_we <= 1'b0;
        board.mode_reg = mode;
    endtask

    initial begin
        board = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_position = '0;
        i_palette_mode_we = 1'b0;
        i_palette_mode = icm_pkg::MODE_RAINBOW;
        i_stall = 1'b0;
        calm = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph == 2) || (ph == 9);
            if (ph == 0) begin
                // first phase runs on the reset default of rainbow
                foreach (DIRECTED[j]) send_position(18'(DIRECTED[j]));
            end else begin
                // drain fully before touching the mode register
                i_valid <= 1'b0;
                while (board.color_q.size() != 0) @(negedge i_clk);
                repeat (8) @(negedge i_clk);
                write_mode(PHASE_MODE[ph]);
            end
            for (int j = 0; j < BEATS_PER_PHASE; j++) send_position(random_position());
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // wait for the last colors, then keep watching for any stray beat
        while (board.color_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("interpolated_palette_colormap_top_tb passed");
        end else begin
            $display("interpolated_palette_colormap_top_tb failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #400000;
        $display("interpolated_palette_colormap_top_tb failed");
        $finish;
    end

endmodule
